// ----- rtl/core/cdq_pkg.sv -----
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes of the circular deque: operation codes, status
// codes, the request and response payloads and the default ring depth.
// ---------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    // Operation codes; every other code behaves as a query
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

    // Front and back view of an empty deque
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] popped_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic                     is_empty;
        logic                     is_full;
    } t_rsp;

endpackage

// ----- rtl/core/cdq_stream_if.sv -----
// ---------------------------------------------------------------------------
// cdq_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ---------------------------------------------------------------------------
interface cdq_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/cdq_ring.sv -----
// ---------------------------------------------------------------------------
// cdq_ring
// Entry storage of the deque: one write port, one read port with the read
// data registered.
// ---------------------------------------------------------------------------
module cdq_ring #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic signed [cdq_pkg::WORD_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic signed [cdq_pkg::WORD_W-1:0] o_rd_data
);

    logic signed [cdq_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic signed [cdq_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/circular_deque.sv -----
// ---------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words kept in a ring of DEPTH entries.
// ---------------------------------------------------------------------------
// Usage:
//   i_req (sink) takes one request per transfer: mode selects push front,
//   push back, pop front, pop back or query (unused codes act as query);
//   value is the word to push. o_rsp (source) returns exactly one response
//   per request, in order: status, popped word, front and back words after
//   the operation (-1 when empty) and the empty/full flags.
//   Pushes, queries, failed operations and a pop of the last word answer in
//   the cycle after the request transfer and sustain one request per cycle
//   while o_rsp.ready stays high. A pop that leaves words behind answers
//   from S_FETCH, because the new front or back word comes from the single
//   read port of the entry ring, whose read data is registered; such a pop
//   holds the input while that word is fetched. The front and back words
//   are also cached in registers, so pushes never wait on the ring.
//   Reset (i_rst_n low, synchronous) empties the deque; the ring contents
//   are not cleared, since no entry is read before it is written.
//   A response waits in the output register while o_rsp.ready is low; a new
//   request is taken only when that register is empty or drains in the same
//   cycle, so nothing is dropped under backpressure.
// ---------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdq_stream_if.sink   i_req,
    cdq_stream_if.source o_rsp
);

    localparam int IW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    // Ring index helpers; DEPTH need not be a power of two
    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx);
        return (idx == '0) ? IW'(DEPTH - 1) : idx - IW'(1);
    endfunction

    // Control state
    t_state           r_state, n_state;
    logic [IW-1:0]    r_head, n_head;
    logic [IW-1:0]    r_tail, n_tail;
    logic             r_occ, n_occ;
    logic             r_out_valid, n_out_valid;

    // Cached end words and pending fetch side
    logic signed [cdq_pkg::WORD_W-1:0] r_front, n_front;
    logic signed [cdq_pkg::WORD_W-1:0] r_back, n_back;
    logic                              r_fetch_front, n_fetch_front;
    cdq_pkg::t_rsp                     r_out, n_out;

    // Ring port signals
    logic                              wr_en;
    logic [IW-1:0]                     wr_addr;
    logic                              rd_en;
    logic [IW-1:0]                     rd_addr;
    logic signed [cdq_pkg::WORD_W-1:0] rd_data;

    logic accept;
    logic is_push;
    logic is_pop;
    logic full_now;
    logic load_view;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign is_push  = (i_req.data.mode == cdq_pkg::MODE_PUSH_FRONT) ||
                      (i_req.data.mode == cdq_pkg::MODE_PUSH_BACK);
    assign is_pop   = (i_req.data.mode == cdq_pkg::MODE_POP_FRONT) ||
                      (i_req.data.mode == cdq_pkg::MODE_POP_BACK);
    assign full_now = r_occ && (wrap_inc(r_tail) == r_head);

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_occ         = r_occ;
        n_front       = r_front;
        n_back        = r_back;
        n_fetch_front = r_fetch_front;
        n_out         = r_out;
        // Drop the held response once it transfers
        n_out_valid   = r_out_valid && !o_rsp.ready;
        wr_en         = 1'b0;
        wr_addr       = r_head;
        rd_en         = 1'b0;
        rd_addr       = r_head;
        load_view     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.status       = cdq_pkg::STAT_OK;
                    n_out.popped_value = '0;
                    load_view          = 1'b1;
                    if (is_push) begin
                        if (!r_occ) begin
                            // First word always lands in entry zero
                            n_head  = '0;
                            n_tail  = '0;
                            n_occ   = 1'b1;
                            n_front = i_req.data.value;
                            n_back  = i_req.data.value;
                            wr_en   = 1'b1;
                            wr_addr = '0;
                        end else if (full_now) begin
                            n_out.status = cdq_pkg::STAT_OVERFLOW;
                        end else if (i_req.data.mode == cdq_pkg::MODE_PUSH_FRONT) begin
                            n_head  = wrap_dec(r_head);
                            n_front = i_req.data.value;
                            wr_en   = 1'b1;
                            wr_addr = wrap_dec(r_head);
                        end else begin
                            n_tail  = wrap_inc(r_tail);
                            n_back  = i_req.data.value;
                            wr_en   = 1'b1;
                            wr_addr = wrap_inc(r_tail);
                        end
                    end else if (is_pop) begin
                        if (!r_occ) begin
                            n_out.status = cdq_pkg::STAT_UNDERFLOW;
                        end else if (r_head == r_tail) begin
                            // Last word leaves; deque returns to its reset shape
                            n_out.popped_value = r_front;
                            n_head             = '0;
                            n_tail             = '0;
                            n_occ              = 1'b0;
                        end else if (i_req.data.mode == cdq_pkg::MODE_POP_FRONT) begin
                            n_out.popped_value = r_front;
                            n_head             = wrap_inc(r_head);
                            rd_en              = 1'b1;
                            rd_addr            = wrap_inc(r_head);
                            n_fetch_front      = 1'b1;
                            n_state            = S_FETCH;
                            load_view          = 1'b0;
                        end else begin
                            n_out.popped_value = r_back;
                            n_tail             = wrap_dec(r_tail);
                            rd_en              = 1'b1;
                            rd_addr            = wrap_dec(r_tail);
                            n_fetch_front      = 1'b0;
                            n_state            = S_FETCH;
                            load_view          = 1'b0;
                        end
                    end
                end
            end
            S_FETCH: begin
                // Ring data for the new end word is valid this cycle
                if (r_fetch_front) begin
                    n_front = rd_data;
                end else begin
                    n_back = rd_data;
                end
                load_view = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Fill the view of the deque after the operation and post the response
        if (load_view) begin
            n_out.front_value = n_occ ? n_front : cdq_pkg::EMPTY_WORD;
            n_out.back_value  = n_occ ? n_back : cdq_pkg::EMPTY_WORD;
            n_out.is_empty    = !n_occ;
            n_out.is_full     = n_occ && (wrap_inc(n_tail) == n_head);
            n_out_valid       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge i_clk) begin
        r_front       <= n_front;
        r_back        <= n_back;
        r_fetch_front <= n_fetch_front;
        r_out         <= n_out;
    end

    cdq_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_req.data.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // An emptied deque always sits at index zero
    a_empty_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_occ |-> (r_head == '0) && (r_tail == '0))
        else $error("empty deque with nonzero head or tail");

    // The output slot is free whenever a ring fetch completes
    a_fetch_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> !r_out_valid)
        else $error("ring fetch with a response still held");

    // A pop that leaves words behind enters the fetch state in the cycle after its transfer
    a_fetch_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_pop && r_occ && (r_head != r_tail)) |=> (r_state == S_FETCH))
        else $error("pop did not start a ring fetch");

    // A push into a full deque leaves the indices alone
    a_overflow_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_push && full_now) |=> $stable(r_head) && $stable(r_tail) && r_occ)
        else $error("overflowing push moved the indices");

    // Full and empty never coincide in a response
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.is_full && r_out.is_empty))
        else $error("response reports full and empty together");

endmodule
